### sv/mcbsm_pkg.sv
// ----------------------------------------------------------------------------
// mcbsm_pkg: shared types and constants for the multicart bank switch mapper
// Item and result formats, op codes, register indexes and fixed bank values.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbsm_pkg;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_XLATE = 2'd1,
    OP_PPU_XLATE = 2'd2
  } op_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_MASK = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_MASK = 1'd1;

  localparam logic [6:0] PRG_MASK_RESET = 7'h7F;
  localparam logic [9:0] CHR_MASK_RESET = 10'h3FF;

  // Register decode at 0x8000+
  localparam logic [15:0] SEL_MASK        = 16'hE001;
  localparam logic [15:0] SEL_BANK_SELECT = 16'h8000;
  localparam logic [15:0] SEL_BANK_DATA   = 16'h8001;

  // Outer register write window 0x6000-0x7FFF: top three address bits
  localparam logic [2:0] OUTER_WINDOW = 3'b011;

  localparam logic [7:0] PRG_SECOND_LAST = 8'hFE;
  localparam logic [7:0] PRG_LAST        = 8'hFF;

  localparam logic [6:0] PRG_INNER_SMALL = 7'h0F;
  localparam logic [6:0] PRG_INNER_LARGE = 7'h1F;
  localparam logic [7:0] CHR_INNER_SMALL = 8'h7F;
  localparam logic [7:0] CHR_INNER_LARGE = 8'hFF;

  localparam logic [7:0] INNER_RESET [8] = '{
    8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0
  };

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  value;
    logic        prg_ram_write_enable;
  } item_t;

  typedef struct packed {
    logic [9:0] bank;
    logic       uses_chr_ram;
    logic       forwarded;
  } result_t;

endpackage

`default_nettype wire

### sv/multicart_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// multicart_bank_switch_mapper: multicart mapper with lockable outer register
// Takes CPU writes and CPU/PPU address lookups, returns one result per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser op; tdata address, value, wren
//  m_*       out        m_tvalid / m_tready  tdata bank, forwarded; tuser chr ram
//  cfg_*     in         cfg_we               cfg_index, cfg_data
//
//  One item per cycle sustained while m_tready stays high; a result reaches
//  the output through the input register, then the result register.
//  The state update of a write lands when the item leaves the input register,
//  so the next item sees it with no bubble.
//  A stalled result holds the output; one more item waits in the input
//  register, then s_tready drops.
//  rst is synchronous: it empties both registers and restores mapper state.
// ----------------------------------------------------------------------------
`default_nettype none

module multicart_bank_switch_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [15:0] address, [23:16] value, [24] prg_ram_write_enable, [31:25] zero
  input  wire logic [31:0]                        s_tdata,
  // [1:0] op
  input  wire logic [1:0]                         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [9:0] bank, [10] forwarded, [15:11] zero
  output logic [15:0]                             m_tdata,
  // [0] uses_chr_ram
  output logic                                    m_tuser,
  input  wire logic                               cfg_we,
  input  wire logic [mcbsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mcbsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mcbsm_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    out_load;
  logic    advance;

  assign out_load = !out_valid || m_tready;
  assign advance  = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op                   <= op_t'(s_tuser);
      in_item.address              <= s_tdata[15:0];
      in_item.value                <= s_tdata[23:16];
      in_item.prg_ram_write_enable <= s_tdata[24];
    end
  end

  mcbsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (in_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_result.forwarded, out_result.bank};
  assign m_tuser  = out_result.uses_chr_ram;

endmodule

`default_nettype wire

### sv/mcbsm_core.sv
// ----------------------------------------------------------------------------
// mcbsm_core: mapper state and bank translation
// Holds outer, bank select, inner bank and mask registers; computes the
// result of one item and updates the state when the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbsm_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mcbsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mcbsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                               fire,
  input  wire mcbsm_pkg::item_t                   item,
  output mcbsm_pkg::result_t                      result
);
  import mcbsm_pkg::*;

  logic [6:0] prg_bank_mask;
  logic [9:0] chr_bank_mask;
  logic [5:0] outer;
  logic [7:0] bank_select;
  logic [7:0] inner_banks [8];

  logic       outer_hit;
  logic       reg_hit;
  logic [7:0] prg_inner;
  logic [6:0] prg_base;
  logic [6:0] prg_mask;
  logic [6:0] prg_bank;
  logic [2:0] chr_slot;
  logic [2:0] chr_sel;
  logic [7:0] chr_inner;
  logic [7:0] chr_mask;
  logic [9:0] chr_bank;
  logic [15:0] sel;

  assign outer_hit = (item.address[15:13] == OUTER_WINDOW);
  assign reg_hit   = item.address[15];
  assign sel       = item.address & SEL_MASK;

  // PRG: 8 KB slot from address bits 14:13
  always_comb begin
    case (item.address[14:13])
      2'd0:    prg_inner = bank_select[6] ? PRG_SECOND_LAST : inner_banks[6];
      2'd1:    prg_inner = inner_banks[7];
      2'd2:    prg_inner = bank_select[6] ? inner_banks[6] : PRG_SECOND_LAST;
      default: prg_inner = PRG_LAST;
    endcase
  end

  assign prg_base = {outer[2:0], 4'b0000};
  assign prg_mask = outer[3] ? PRG_INNER_LARGE : PRG_INNER_SMALL;
  assign prg_bank = ((prg_base & ~prg_mask) | (prg_inner[6:0] & prg_mask)) & prg_bank_mask;

  // CHR: 1 KB slot, inverted halves when bank select bit 7 is set
  assign chr_slot = item.address[12:10];
  assign chr_sel  = chr_slot ^ {bank_select[7], 2'b00};

  always_comb begin
    case (chr_sel)
      3'd0:    chr_inner = inner_banks[0] & 8'hFE;
      3'd1:    chr_inner = inner_banks[0] | 8'h01;
      3'd2:    chr_inner = inner_banks[1] & 8'hFE;
      3'd3:    chr_inner = inner_banks[1] | 8'h01;
      default: chr_inner = inner_banks[chr_sel - 3'd2];
    endcase
  end

  assign chr_mask = outer[5] ? CHR_INNER_LARGE : CHR_INNER_SMALL;
  assign chr_bank = ({outer[2:0], 7'b0000000} | {2'b00, chr_inner & chr_mask}) & chr_bank_mask;

  always_comb begin
    result = '0;
    case (item.op)
      OP_CPU_WRITE: begin
        if (reg_hit && sel != SEL_BANK_SELECT && sel != SEL_BANK_DATA) begin
          result.forwarded = 1'b1;
        end
      end
      OP_CPU_XLATE: begin
        if (reg_hit) begin
          result.bank = {3'b000, prg_bank};
        end
      end
      OP_PPU_XLATE: begin
        if (outer[4]) begin
          result.bank         = {7'b0000000, chr_slot};
          result.uses_chr_ram = 1'b1;
        end else begin
          result.bank = chr_bank;
        end
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_mask <= PRG_MASK_RESET;
      chr_bank_mask <= CHR_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_BANK_MASK: prg_bank_mask <= cfg_data[6:0];
        CFG_CHR_BANK_MASK: chr_bank_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer       <= '0;
      bank_select <= '0;
      for (int i = 0; i < 8; i++) begin
        inner_banks[i] <= INNER_RESET[i];
      end
    end else if (fire && item.op == OP_CPU_WRITE) begin
      if (outer_hit) begin
        // lock once the outer base is nonzero
        if (item.prg_ram_write_enable && outer[2:0] == 3'b000) begin
          outer <= item.address[5:0];
        end
      end else if (reg_hit) begin
        if (sel == SEL_BANK_SELECT) begin
          bank_select <= item.value;
        end else if (sel == SEL_BANK_DATA) begin
          inner_banks[bank_select[2:0]] <= item.value;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/mcbsm_checker.sv
// ----------------------------------------------------------------------------
// mcbsm_checker: port-level checks for the multicart bank switch mapper
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser
);

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_chr_ram_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10] == 1'b0 && m_tdata[9:3] == 7'd0)
    else $error("CHR RAM result with forwarded flag or page above 7");

  a_forward_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tuser && m_tdata[9:0] == 10'd0)
    else $error("forwarded write carries a bank");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tready ##1 m_tready |=> m_tvalid)
    else $error("result missing two cycles after transfer in");

endmodule

bind multicart_bank_switch_mapper mcbsm_checker u_mcbsm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
